/* hw/rtl/tzl_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the time-zone offset lookup.
// No dependencies; tzl_ctrl, the top level and the bench import this package.
package tzl_pkg;

	localparam int DEF_TABLE_DEPTH = 1024;

	localparam int START_W    = 32;
	localparam int OFFSET_W   = 16;
	localparam int WORD_W     = START_W + OFFSET_W;
	localparam int INDEX_W    = 10;
	localparam int COUNT_W    = 11;
	localparam int QUERY_W    = 64;
	localparam int OUT_OFF_W  = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_ENTRY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EPOCH_BASE  = 2'd2;

	typedef struct packed {
		logic [INDEX_W-1:0] first_entry;
		logic [COUNT_W-1:0] entry_count;
		logic [START_W-1:0] epoch_base;
	} cfg_t;

	typedef struct packed {
		logic [OUT_OFF_W-1:0] utc_offset;
		logic [INDEX_W-1:0]   entry_used;
		logic                 zone_set;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAST,
		ST_SRCH,
		ST_OFF,
		ST_DONE
	} state_t;

endpackage

/* hw/rtl/tzl_ram.sv */
`timescale 1ns / 1ps
// Transition table: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module tzl_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 48
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/tzl_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer and datapath of the lookup: table writes, range clipping and the
// binary search, one table probe per cycle. Uses tzl_pkg and drives tzl_ram.
module tzl_ctrl
	import tzl_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int AW          = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic [INDEX_W-1:0]         entry_index,
	input  logic [START_W-1:0]         start_word,
	input  logic signed [OFFSET_W-1:0] offset_tens,
	input  logic signed [QUERY_W-1:0]  query_time,
	output logic                       res_valid,
	input  logic                       res_ready,
	output res_t                       res,
	output logic                       ram_we,
	output logic [AW-1:0]              ram_waddr,
	output logic [WORD_W-1:0]          ram_wdata,
	output logic                       ram_re,
	output logic [AW-1:0]              ram_raddr,
	input  logic [WORD_W-1:0]          ram_rdata
);

	localparam int SW = ((AW > COUNT_W) ? AW : COUNT_W) + 1;
	localparam logic [SW-1:0] DEPTH_W = SW'(TABLE_DEPTH);

	state_t state_q, state_d;

	logic [AW-1:0]      lo_q, hi_q, pick_q, mid_q;
	logic [AW-1:0]      lo_n, hi_n, pick_n, mid_n;
	logic [AW:0]        mid_sum;
	logic               go_search;
	logic               t_neg_q, t_big_q;
	logic [START_W-1:0] t_lo_q;
	res_t               res_q;

	logic               accept;
	logic [SW-1:0]      idx_w, f_w, c_w, avail, cnt, last_w;
	logic               idx_ok, empty;
	logic [QUERY_W:0]   diff;
	logic [START_W-1:0] rd_start;
	logic [OFFSET_W-1:0] rd_off;
	logic [OUT_OFF_W-1:0] off_ext, off_x10;
	logic [SW-1:0]      pick_w;
	logic               le;

	assign accept = in_valid && (state_q == ST_IDLE);

	assign idx_w  = SW'(entry_index);
	assign idx_ok = idx_w < DEPTH_W;

	// clip the configured range to the table
	always_comb begin
		f_w   = SW'(cfg.first_entry);
		c_w   = SW'(cfg.entry_count);
		avail = DEPTH_W - f_w;
		if (f_w >= DEPTH_W) begin
			cnt = '0;
		end else if (c_w > avail) begin
			cnt = avail;
		end else begin
			cnt = c_w;
		end
		empty  = (cnt == '0);
		last_w = f_w + cnt - SW'(1);
	end

	assign diff = {query_time[QUERY_W-1], query_time} - {{(QUERY_W-START_W+1){1'b0}},
		cfg.epoch_base};

	assign rd_start = ram_rdata[START_W-1:0];
	assign rd_off   = ram_rdata[WORD_W-1:START_W];
	assign le       = !t_neg_q && (t_big_q || (rd_start <= t_lo_q));

	assign off_ext = {{(OUT_OFF_W-OFFSET_W){rd_off[OFFSET_W-1]}}, rd_off};
	assign off_x10 = (off_ext << 3) + (off_ext << 1);
	assign pick_w  = SW'(pick_q);

	// search step
	always_comb begin
		lo_n   = lo_q;
		hi_n   = hi_q;
		pick_n = pick_q;
		unique case (state_q)
			ST_IDLE: begin
				lo_n   = f_w[AW-1:0];
				hi_n   = last_w[AW-1:0];
				pick_n = f_w[AW-1:0];
			end
			ST_LAST: begin
				pick_n = le ? hi_q : lo_q;
			end
			ST_SRCH: begin
				if (le) begin
					pick_n = mid_q;
					lo_n   = mid_q + AW'(1);
				end else begin
					hi_n = mid_q;
				end
			end
			default: begin
			end
		endcase
		mid_sum   = {1'b0, lo_n} + {1'b0, hi_n};
		mid_n     = mid_sum[AW:1];
		go_search = (lo_n < hi_n) && !((state_q == ST_LAST) && le);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (op == OP_QUERY && !empty) ? ST_LAST : ST_DONE;
				end
			end
			ST_LAST, ST_SRCH: state_d = go_search ? ST_SRCH : ST_OFF;
			ST_OFF:           state_d = ST_DONE;
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default:          state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		res_valid = (state_q == ST_DONE);
		ram_we    = accept && (op == OP_WRITE) && idx_ok;
		ram_waddr = idx_w[AW-1:0];
		ram_wdata = {offset_tens, start_word};
		ram_re    = 1'b0;
		ram_raddr = go_search ? mid_n : pick_n;
		unique case (state_q)
			ST_IDLE: begin
				ram_re    = accept && (op == OP_QUERY) && !empty;
				ram_raddr = last_w[AW-1:0];
			end
			ST_LAST, ST_SRCH: ram_re = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q   <= lo_n;
		hi_q   <= hi_n;
		pick_q <= pick_n;
		mid_q  <= mid_n;
		if (accept) begin
			t_neg_q <= diff[QUERY_W];
			t_big_q <= !diff[QUERY_W] && (|diff[QUERY_W-1:START_W]);
			t_lo_q  <= diff[START_W-1:0];
			res_q   <= '0;
		end
		if (state_q == ST_OFF) begin
			res_q.utc_offset <= off_x10;
			res_q.entry_used <= pick_w[INDEX_W-1:0];
			res_q.zone_set   <= 1'b1;
		end
	end

	assign res = res_q;

endmodule

/* hw/rtl/timezone_offset_lookup.sv */
`timescale 1ns / 1ps
// Top level of the time-zone offset lookup: configuration registers, result
// word register and the instances of tzl_ctrl and tzl_ram. Uses tzl_pkg.
//
//  channel  handshake             payload
//  in       in_valid / in_stall   op, entry_index, start_word, offset_tens, query_time
//  out      out_valid / out_stall utc_offset, entry_used, zone_set
//  cfg      cfg_wr                cfg_index, cfg_data
//
// A write, or a query on an empty zone, goes through ST_DONE to the output register;
// other queries first pass ST_LAST, k binary-search probes in ST_SRCH (k up to about
// log2 of the clipped count) and ST_OFF; the table read port gives one probe a cycle.
// One word is in work at a time; the next input is taken while a result waits.
// Reset clears the configuration and control state; the table is not cleared.
module timezone_offset_lookup
	import tzl_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        op,
	input  logic [INDEX_W-1:0]          entry_index,
	input  logic [START_W-1:0]          start_word,
	input  logic signed [OFFSET_W-1:0]  offset_tens,
	input  logic signed [QUERY_W-1:0]   query_time,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [OUT_OFF_W-1:0] utc_offset,
	output logic [INDEX_W-1:0]          entry_used,
	output logic                        zone_set
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	cfg_t              cfg_q;
	res_t              res, out_q;
	logic              res_valid, res_ready, out_valid_q;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_FIRST_ENTRY: cfg_q.first_entry <= cfg_data[INDEX_W-1:0];
				REG_ENTRY_COUNT: cfg_q.entry_count <= cfg_data[COUNT_W-1:0];
				REG_EPOCH_BASE:  cfg_q.epoch_base  <= cfg_data[START_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tzl_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW         (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.entry_index(entry_index),
		.start_word (start_word),
		.offset_tens(offset_tens),
		.query_time (query_time),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	tzl_ram #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW),
		.DW   (WORD_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// hold the result word until taken
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign utc_offset = $signed(out_q.utc_offset);
	assign entry_used = out_q.entry_used;
	assign zone_set   = out_q.zone_set;

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input word taken while another is in work");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> out_valid)
		else $error("result word lost on its way to the output");

	a_no_zone_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zone_set |-> utc_offset == '0 && entry_used == '0)
		else $error("result without zone carries non-zero fields");
`endif

endmodule

/* tb/timezone_offset_lookup_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for timezone_offset_lookup: loads transition tables, runs lookups
// under random idling on both channels and checks every result word against a table
// search kept in the bench. Depends on tzl_pkg and the block's RTL only.
module timezone_offset_lookup_tb;
	import tzl_pkg::*;

	localparam int DEPTH = DEF_TABLE_DEPTH;

	typedef struct {
		logic                op;
		logic [INDEX_W-1:0]  index;
		logic [START_W-1:0]  start;
		logic [OFFSET_W-1:0] tens;
		longint              qtime;
	} tz_word_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_wr = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic                        op = OP_WRITE;
	logic [INDEX_W-1:0]          entry_index = '0;
	logic [START_W-1:0]          start_word = '0;
	logic signed [OFFSET_W-1:0]  offset_tens = '0;
	logic signed [QUERY_W-1:0]   query_time = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [OUT_OFF_W-1:0] utc_offset;
	logic [INDEX_W-1:0]          entry_used;
	logic                        zone_set;

	timezone_offset_lookup dut (.*);

	// bench copy of the table and the zone registers
	logic [START_W-1:0]  start_mem [DEPTH];
	logic [OFFSET_W-1:0] tens_mem [DEPTH];
	logic [INDEX_W-1:0]  zone_first = '0;
	logic [COUNT_W-1:0]  zone_count = '0;
	logic [START_W-1:0]  zone_base = '0;

	// what the stimulus has queued so far
	logic [START_W-1:0] planned_start [DEPTH];
	bit                 filled [DEPTH];

	tz_word_t send_words [$];
	res_t     due_offsets [$];
	tz_word_t cur_word;
	res_t     want;
	bit       in_taken = 1'b0;
	bit       out_taken = 1'b0;
	int       gap_left = 0;
	int       hold_left = 0;
	bit       send_idle = 1'b1;
	bit       recv_idle = 1'b1;
	bit       choke = 1'b0;
	bit       pressure_go = 1'b0;
	int       fail_count = 0;
	int       checked = 0;
	int       zoned = 0;
	int       n_writes = 0;
	int       n_queries = 0;
	int       n_zones = 0;
	int       word_total = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint start_at(int unsigned i);
		return longint'({32'd0, start_mem[i]}) + longint'({32'd0, zone_base});
	endfunction

	function automatic res_t lookup_offset(tz_word_t w);
		res_t        r;
		int unsigned cnt, lst, lo, hi, mid, pick;
		int          scaled;
		r = '0;
		if (w.op == OP_WRITE) begin
			start_mem[w.index] = w.start;
			tens_mem[w.index] = w.tens;
			return r;
		end
		cnt = zone_count;
		if (zone_first >= DEPTH) cnt = 0;
		else if (cnt > DEPTH - zone_first) cnt = DEPTH - zone_first;
		if (cnt == 0) return r;
		lst = zone_first + cnt - 1;
		pick = zone_first;
		if (start_at(lst) <= w.qtime) begin
			pick = lst;
		end else begin
			lo = zone_first;
			hi = lst;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (start_at(mid) <= w.qtime) begin
					pick = mid;
					lo = mid + 1;
				end else begin
					hi = mid;
				end
			end
		end
		scaled = int'($signed(tens_mem[pick])) * 10;
		r.utc_offset = scaled[OUT_OFF_W-1:0];
		r.entry_used = pick[INDEX_W-1:0];
		r.zone_set = 1'b1;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
		fail_count++;
		$display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want_v, got_v);
	endtask

	// sender: hold a stalled word, otherwise idle or present the next one
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (in_valid) gap_left = send_idle ? $urandom_range(0, 9) : 0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (send_words.size() > 0) begin
				cur_word = send_words.pop_front();
				op <= cur_word.op;
				entry_index <= cur_word.index;
				start_word <= cur_word.start;
				offset_tens <= cur_word.tens;
				query_time <= cur_word.qtime;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) due_offsets.push_back(lookup_offset(cur_word));
	end

	// receiver: after each word stall for a random hold when idling is on; stall throughout a choke
	always @(negedge clk) begin
		if (out_taken) hold_left = recv_idle ? $urandom_range(0, 9) : 0;
		if (choke) begin
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		out_taken <= arst_n && out_valid && !out_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (due_offsets.size() == 0) begin
				report_mismatch("unexpected word", '0, '0);
			end else begin
				want = due_offsets.pop_front();
				checked++;
				if (want.zone_set) zoned++;
				if (utc_offset !== want.utc_offset)
					report_mismatch("utc_offset", 64'(want.utc_offset), 64'(utc_offset));
				if (entry_used !== want.entry_used)
					report_mismatch("entry_used", 64'(want.entry_used), 64'(entry_used));
				if (zone_set !== want.zone_set)
					report_mismatch("zone_set", 64'(want.zone_set), 64'(zone_set));
			end
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		wait (pressure_go);
		@(posedge clk) choke <= 1'b1;
		repeat (200) @(posedge clk);
		choke <= 1'b0;
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic push_write(int unsigned idx, logic [START_W-1:0] st, logic [OFFSET_W-1:0] tens);
		tz_word_t w;
		w.op = OP_WRITE;
		w.index = idx[INDEX_W-1:0];
		w.start = st;
		w.tens = tens;
		w.qtime = {$urandom, $urandom};
		send_words.push_back(w);
		planned_start[idx] = st;
		filled[idx] = 1'b1;
		n_writes++;
		word_total++;
	endtask

	task automatic push_query(longint t);
		tz_word_t w;
		w.op = OP_QUERY;
		w.index = INDEX_W'($urandom);
		w.start = $urandom;
		w.tens = OFFSET_W'($urandom);
		w.qtime = t;
		send_words.push_back(w);
		n_queries++;
		word_total++;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (send_words.size() != 0 || in_valid || due_offsets.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr <= 1'b0;
	endtask

	task automatic set_zone(int unsigned f, int unsigned c, logic [START_W-1:0] b);
		wait_idle();
		write_reg(REG_FIRST_ENTRY, CFG_DATA_W'(INDEX_W'(f)));
		write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(COUNT_W'(c)));
		write_reg(REG_EPOCH_BASE, b);
		zone_first = INDEX_W'(f);
		zone_count = COUNT_W'(c);
		zone_base = b;
		n_zones++;
	endtask

	function automatic longint pick_time(int unsigned f, int unsigned cnt, logic [START_W-1:0] b);
		longint s;
		s = longint'({32'd0, planned_start[f + $urandom_range(0, cnt - 1)]}) + longint'({32'd0, b});
		case ($urandom_range(0, 9))
			4: return s - 1;
			5: return s + 1;
			6: return {1'b1, 31'($urandom), 32'($urandom)};
			7: return {$urandom, $urandom};
			8: return $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
			9: return s + $urandom_range(0, 100000);
			default: return s;
		endcase
	endfunction

	// configure a zone, load its range (non-decreasing starts when sorted, else only
	// entries not yet written), then mix lookups with stray writes
	task automatic run_zone(int unsigned f, int unsigned c, logic [START_W-1:0] b, bit sorted,
			int unsigned extra);
		int unsigned    cnt, i;
		logic [START_W-1:0] s;
		set_zone(f, c, b);
		cnt = (c > DEPTH - f) ? DEPTH - f : c;
		s = $urandom & 32'h7FFF_FFFF;
		for (i = f; i < f + cnt; i++) begin
			if (sorted) begin
				if ($urandom_range(0, 3) != 0) s += $urandom_range(1, 1 << 20);
				push_write(i, s, OFFSET_W'($urandom));
			end else if (!filled[i]) begin
				push_write(i, $urandom, OFFSET_W'($urandom));
			end
		end
		repeat (extra) begin
			if ($urandom_range(0, 4) == 0)
				push_write($urandom_range(0, DEPTH - 1), $urandom, OFFSET_W'($urandom));
			else if (cnt == 0) push_query({$urandom, $urandom});
			else push_query(pick_time(f, cnt, b));
		end
	endtask

	initial begin
		int unsigned        f, c;
		logic [START_W-1:0] b;
		bit                 big_done;
		big_done = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// empty zone straight out of reset, then extreme entries
		push_query(64'h7FFF_FFFF_FFFF_FFFF);
		push_write(0, 32'h0, 16'h8000);
		push_write(1, 32'd100, 16'h7FFF);
		push_write(DEPTH - 1, 32'hFFFF_FFFF, 16'h7FFF);
		push_write(2, 32'h8000_0000, 16'hFFFF);
		set_zone(DEPTH - 1, 1, 32'hFFFF_FFFF);
		push_query(64'h8000_0000_0000_0000);
		push_query(64'h7FFF_FFFF_FFFF_FFFF);
		push_query(64'h1_FFFF_FFFE);
		push_query(64'h1_FFFF_FFFD);
		set_zone(0, 3, 0);
		push_query(-1);
		push_query(0);
		push_query(99);
		push_query(100);
		push_query(64'h8000_0000);
		// range running past the table end
		set_zone(DEPTH - 1, DEPTH, 0);
		push_query(0);
		set_zone(5, 0, 7);
		push_query(100);

		word_total = 0;
		while (word_total < 950) begin
			send_idle = $urandom_range(0, 3) != 0;
			recv_idle = $urandom_range(0, 3) != 0;
			if (n_zones == 8) send_idle = 1'b0;
			if (!big_done && word_total >= 300) begin
				big_done = 1'b1;
				run_zone(0, DEPTH / 2, $urandom, 1'b0, 60);
			end else begin
				case ($urandom_range(0, 5))
					0: c = 0;
					1: c = DEPTH;
					2: c = 1;
					default: c = $urandom_range(2, 48);
				endcase
				case ($urandom_range(0, 5))
					0: f = 0;
					1: f = DEPTH - 1;
					default: f = $urandom_range(0, DEPTH - 1);
				endcase
				if (c == DEPTH) f = $urandom_range(DEPTH - 64, DEPTH - 1);
				case ($urandom_range(0, 3))
					0: b = '0;
					1: b = '1;
					default: b = $urandom;
				endcase
				run_zone(f, c, b, $urandom_range(0, 3) != 0, $urandom_range(20, 60));
			end
			if (n_zones == 9) pressure_go = 1'b1;
		end

		wait_idle();
		$display("Ran %0d table writes and %0d lookups over %0d zone settings.",
			n_writes, n_queries, n_zones);
		$display("%0d result words checked, %0d of them with a zone set, %0d mismatches.",
			checked, zoned, fail_count);
		if (fail_count == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
